// ----- rtl/dlle_pkg.sv -----
// Package for the doubly linked list engine: command and status codes.
// Used by doubly_linked_list_engine_core and its checker.
`timescale 1ns / 1ps
package dlle_pkg;
    localparam logic [3:0] CMD_ADD_BACK   = 4'd0;
    localparam logic [3:0] CMD_ADD_FRONT  = 4'd1;
    localparam logic [3:0] CMD_INS_BEFORE = 4'd2;
    localparam logic [3:0] CMD_INS_AFTER  = 4'd3;
    localparam logic [3:0] CMD_DEL_FIRST  = 4'd4;
    localparam logic [3:0] CMD_DEL_LAST   = 4'd5;
    localparam logic [3:0] CMD_DEL_BEFORE = 4'd6;
    localparam logic [3:0] CMD_DEL_AT     = 4'd7;
    localparam logic [3:0] CMD_DEL_AFTER  = 4'd8;
    localparam logic [3:0] CMD_CONTAINS   = 4'd9;
    localparam logic [3:0] CMD_CLEAR      = 4'd10;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_NOCHG  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
endpackage

// ----- rtl/dlle_ram.sv -----
// Generic single-port RAM with registered read, one write or read per cycle.
// No dependencies.
`timescale 1ns / 1ps
module dlle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write or read one entry
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ----- rtl/doubly_linked_list_engine_core.sv -----
// Doubly linked list engine: one item at a time through a small sequencer.
// A push writes the new node, then links its predecessor and successor (a recycled
// slot is first popped from the pool). Deleting the first or last node reads its
// links, unlinks it and returns its slot to the pool; clear or an unknown command
// goes straight to the result. Searches walk the list node by node (read, compare,
// follow the next link). Ready is low while busy. Reset (aresetn, synchronous) empties the list.
`timescale 1ns / 1ps
module doubly_linked_list_engine_core #(
    parameter int CAPACITY    = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [3:0]                    s_command,
    input  logic signed [31:0]            s_target_key,
    input  logic signed [31:0]            s_item_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic                          m_found,
    output logic [$clog2(CAPACITY+1)-1:0] m_entry_count
);
    localparam int AW = $clog2(CAPACITY);
    localparam int LW = $clog2(CAPACITY+1);
    localparam logic [LW-1:0] NIL = LW'(CAPACITY);

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DISP   = 4'd1;
    localparam logic [3:0] S_POP    = 4'd2;
    localparam logic [3:0] S_SRCH   = 4'd3;
    localparam logic [3:0] S_SCMP   = 4'd4;
    localparam logic [3:0] S_SNXT   = 4'd5;
    localparam logic [3:0] S_MATCH  = 4'd6;
    localparam logic [3:0] S_INSW   = 4'd7;
    localparam logic [3:0] S_INSP   = 4'd8;
    localparam logic [3:0] S_INSN   = 4'd9;
    localparam logic [3:0] S_DELR   = 4'd10;
    localparam logic [3:0] S_DELW   = 4'd11;
    localparam logic [3:0] S_DELP   = 4'd12;
    localparam logic [3:0] S_DELN   = 4'd13;
    localparam logic [3:0] S_OUT    = 4'd14;
    localparam logic [3:0] S_WAIT   = 4'd15;

    logic [3:0]             state_reg;
    logic [3:0]             cmd_reg;
    logic [VALUE_WIDTH-1:0] key_reg, val_reg;
    logic [LW-1:0]          head_reg, tail_reg, count_reg, fresh_reg, rdepth_reg;
    logic [LW-1:0]          cur_reg, slot_reg, p_reg, n_reg;
    logic [LW-1:0]          steps_reg;
    logic [1:0]             status_reg;
    logic                   found_reg;

    // RAM ports
    logic                   v_we, nx_we, pv_we, rc_we;
    logic [AW-1:0]          v_addr, nx_addr, pv_addr, rc_addr;
    logic [VALUE_WIDTH-1:0] v_wd, v_rd;
    logic [LW-1:0]          nx_wd, nx_rd, pv_wd, pv_rd;
    logic [AW-1:0]          rc_wd, rc_rd;

    dlle_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_val (
        .aclk(aclk), .we(v_we), .addr(v_addr), .wdata(v_wd), .rdata(v_rd));
    dlle_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_next (
        .aclk(aclk), .we(nx_we), .addr(nx_addr), .wdata(nx_wd), .rdata(nx_rd));
    dlle_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_prev (
        .aclk(aclk), .we(pv_we), .addr(pv_addr), .wdata(pv_wd), .rdata(pv_rd));
    dlle_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_pool (
        .aclk(aclk), .we(rc_we), .addr(rc_addr), .wdata(rc_wd), .rdata(rc_rd));

    logic is_ins, is_srch;
    assign is_ins  = (cmd_reg <= dlle_pkg::CMD_INS_AFTER);
    assign is_srch = (cmd_reg == dlle_pkg::CMD_INS_BEFORE) ||
                     (cmd_reg == dlle_pkg::CMD_INS_AFTER) ||
                     (cmd_reg == dlle_pkg::CMD_DEL_BEFORE) ||
                     (cmd_reg == dlle_pkg::CMD_DEL_AT) ||
                     (cmd_reg == dlle_pkg::CMD_DEL_AFTER) ||
                     (cmd_reg == dlle_pkg::CMD_CONTAINS);

    logic [VALUE_WIDTH-1:0] probe;
    assign probe = (cmd_reg == dlle_pkg::CMD_CONTAINS) ? val_reg : key_reg;

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = (state_reg == S_WAIT);
    assign m_status      = status_reg;
    assign m_found       = found_reg;
    assign m_entry_count = count_reg;

    // RAM control
    always_comb begin
        v_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0; rc_we = 1'b0;
        v_addr = cur_reg[AW-1:0]; nx_addr = cur_reg[AW-1:0];
        pv_addr = cur_reg[AW-1:0]; rc_addr = AW'(rdepth_reg - LW'(1));
        v_wd = val_reg; nx_wd = n_reg; pv_wd = p_reg; rc_wd = slot_reg[AW-1:0];
        unique case (state_reg)
            S_INSW: begin
                v_we = 1'b1; nx_we = 1'b1; pv_we = 1'b1;
                v_addr = slot_reg[AW-1:0]; nx_addr = slot_reg[AW-1:0];
                pv_addr = slot_reg[AW-1:0];
            end
            S_INSP: begin
                nx_we = (p_reg != NIL); nx_addr = p_reg[AW-1:0]; nx_wd = slot_reg;
            end
            S_INSN: begin
                pv_we = (n_reg != NIL); pv_addr = n_reg[AW-1:0]; pv_wd = slot_reg;
            end
            S_DELR: begin
                nx_addr = slot_reg[AW-1:0]; pv_addr = slot_reg[AW-1:0];
            end
            S_DELP: begin
                nx_we = (p_reg != NIL); nx_addr = p_reg[AW-1:0]; nx_wd = n_reg;
                rc_we = (rdepth_reg < NIL); rc_addr = rdepth_reg[AW-1:0];
            end
            S_DELN: begin
                pv_we = (n_reg != NIL); pv_addr = n_reg[AW-1:0]; pv_wd = p_reg;
            end
            default: begin
            end
        endcase
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            head_reg   <= NIL;
            tail_reg   <= NIL;
            count_reg  <= '0;
            fresh_reg  <= '0;
            rdepth_reg <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: if (s_valid) begin
                    cmd_reg    <= s_command;
                    key_reg    <= VALUE_WIDTH'(64'(s_target_key));
                    val_reg    <= VALUE_WIDTH'(64'(s_item_value));
                    status_reg <= dlle_pkg::ST_NOCHG;
                    found_reg  <= 1'b0;
                    state_reg  <= S_DISP;
                end
                S_DISP: begin
                    cur_reg   <= head_reg;
                    steps_reg <= '0;
                    if (is_ins) begin
                        if (count_reg >= NIL) begin
                            status_reg <= dlle_pkg::ST_FULL; state_reg <= S_OUT;
                        end else if (rdepth_reg != '0) begin
                            rdepth_reg <= rdepth_reg - LW'(1);
                            state_reg  <= S_POP;
                        end else if (fresh_reg < NIL) begin
                            slot_reg  <= fresh_reg;
                            fresh_reg <= fresh_reg + LW'(1);
                            state_reg <= S_SRCH;
                        end else begin
                            status_reg <= dlle_pkg::ST_FULL; state_reg <= S_OUT;
                        end
                    end else if (cmd_reg == dlle_pkg::CMD_DEL_FIRST ||
                                 cmd_reg == dlle_pkg::CMD_DEL_LAST) begin
                        slot_reg  <= (cmd_reg == dlle_pkg::CMD_DEL_FIRST) ?
                                     head_reg : tail_reg;
                        state_reg <= ((cmd_reg == dlle_pkg::CMD_DEL_FIRST ?
                                       head_reg : tail_reg) != NIL) ? S_DELR : S_OUT;
                    end else if (cmd_reg == dlle_pkg::CMD_CLEAR) begin
                        head_reg <= NIL; tail_reg <= NIL; count_reg <= '0;
                        fresh_reg <= '0; rdepth_reg <= '0;
                        status_reg <= dlle_pkg::ST_DONE; state_reg <= S_OUT;
                    end else if (is_srch) begin
                        state_reg <= S_SRCH;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                // wait for pool read
                S_POP: state_reg <= S_SRCH;
                // walk: read value and next link of the current node
                S_SRCH: begin
                    if (cmd_reg == dlle_pkg::CMD_ADD_BACK ||
                        cmd_reg == dlle_pkg::CMD_ADD_FRONT) begin
                        cur_reg   <= NIL;
                        state_reg <= S_MATCH;
                    end else if (cur_reg == NIL || steps_reg >= NIL) begin
                        cur_reg   <= NIL;
                        state_reg <= S_MATCH;
                    end else begin
                        state_reg <= S_SCMP;
                    end
                end
                S_SCMP: begin
                    if (v_rd == probe) begin
                        state_reg <= S_MATCH;
                    end else begin
                        state_reg <= S_SNXT;
                    end
                end
                S_SNXT: begin
                    cur_reg   <= nx_rd;
                    steps_reg <= steps_reg + LW'(1);
                    state_reg <= S_SRCH;
                end
                // match in cur_reg (or NIL); links of cur already on read ports
                S_MATCH: begin
                    if (cmd_reg == dlle_pkg::CMD_CONTAINS) begin
                        found_reg  <= (cur_reg != NIL);
                        status_reg <= dlle_pkg::ST_DONE;
                        state_reg  <= S_OUT;
                    end else if (is_ins) begin
                        state_reg <= S_INSW;
                        if (cmd_reg == dlle_pkg::CMD_ADD_FRONT) begin
                            p_reg <= NIL; n_reg <= head_reg;
                        end else if (cmd_reg == dlle_pkg::CMD_INS_BEFORE && cur_reg != NIL) begin
                            p_reg <= pv_rd; n_reg <= cur_reg;
                        end else if (cmd_reg == dlle_pkg::CMD_INS_AFTER && cur_reg != NIL) begin
                            p_reg <= cur_reg; n_reg <= nx_rd;
                        end else begin
                            p_reg <= tail_reg; n_reg <= NIL;
                        end
                    end else if (cur_reg == NIL) begin
                        state_reg <= S_OUT;
                    end else begin
                        slot_reg <= (cmd_reg == dlle_pkg::CMD_DEL_BEFORE) ? pv_rd :
                                    (cmd_reg == dlle_pkg::CMD_DEL_AT) ? cur_reg : nx_rd;
                        state_reg <= (((cmd_reg == dlle_pkg::CMD_DEL_BEFORE) ? pv_rd :
                                       (cmd_reg == dlle_pkg::CMD_DEL_AT) ? cur_reg : nx_rd)
                                      != NIL) ? S_DELR : S_OUT;
                    end
                end
                S_INSW: state_reg <= S_INSP;
                S_INSP: begin
                    if (p_reg == NIL) head_reg <= slot_reg;
                    state_reg <= S_INSN;
                end
                S_INSN: begin
                    if (n_reg == NIL) tail_reg <= slot_reg;
                    count_reg  <= count_reg + LW'(1);
                    status_reg <= dlle_pkg::ST_DONE;
                    state_reg  <= S_OUT;
                end
                S_DELR: state_reg <= S_DELW;
                S_DELW: begin
                    p_reg <= pv_rd; n_reg <= nx_rd;
                    state_reg <= S_DELP;
                end
                S_DELP: begin
                    if (p_reg == NIL) head_reg <= n_reg;
                    if (rdepth_reg < NIL) rdepth_reg <= rdepth_reg + LW'(1);
                    state_reg <= S_DELN;
                end
                S_DELN: begin
                    if (n_reg == NIL) tail_reg <= p_reg;
                    if (count_reg != '0) count_reg <= count_reg - LW'(1);
                    status_reg <= dlle_pkg::ST_DONE;
                    state_reg  <= S_OUT;
                end
                S_OUT: state_reg <= S_WAIT;
                S_WAIT: if (m_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
            // pool pop: the slot read during dispatch is taken from the pool read port in S_POP
            if (state_reg == S_POP) slot_reg <= LW'(rc_rd);
        end
    end
endmodule

// ----- rtl/dlle_checker.sv -----
// Port-level checker for the list engine, bound to doubly_linked_list_engine_core.
// Depends on doubly_linked_list_engine_core and dlle_pkg.
`timescale 1ns / 1ps
module dlle_checker #(
    parameter int CAPACITY = 256
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [1:0]                    m_status,
    input logic                          m_found,
    input logic [$clog2(CAPACITY+1)-1:0] m_entry_count
);
    // never take an item while a result is pending
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready while result pending");
    // drop ready right after an item is taken
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready) else $error("ready right after accept");
    // count never exceeds capacity while a result is valid
    a_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_entry_count <= ($clog2(CAPACITY+1))'(CAPACITY)))
        else $error("count over capacity");
    // found only with done status
    a_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_found) |-> (m_status == dlle_pkg::ST_DONE))
        else $error("found without done");
    // result valid and entry count held while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_entry_count)))
        else $error("result dropped");
endmodule

bind doubly_linked_list_engine_core dlle_checker #(.CAPACITY(CAPACITY)) u_dlle_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status), .m_found(m_found),
    .m_entry_count(m_entry_count));
